// ===== hdl/vrta_pkg.sv =====
// Shared types, widths and constants for the vector rotate-toward-angle unit.
// Holds the CORDIC arctangent table and the gain correction constant.
// Depends on nothing.
package vrta_pkg;

	localparam int DefSteps = 16;
	localparam int MaxSteps = 32;
	localparam int VecW = 52;
	localparam int ResW = 34;
	localparam int LoSplit = 26;
	localparam logic [31:0] InvGain = 32'd2608131496;
	localparam logic [31:0] HalfTurn = 32'h8000_0000;

	localparam logic [31:0] ATAN_TABLE [MaxSteps] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
		32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162,
		32'd81, 32'd40, 32'd20, 32'd10, 32'd5, 32'd2, 32'd1, 32'd0, 32'd0
	};

	typedef struct packed {
		logic [15:0] tgt;
		logic [14:0] stp;
		logic [31:0] x0;
		logic [31:0] y0;
		logic        zero;
	} side_t;

endpackage

// ===== hdl/vrta_vec_cell.sv =====
// One vectoring cell of the heading chain: a single CORDIC micro-rotation
// that drives y toward zero and accumulates the heading. Uses vrta_pkg.
module vrta_vec_cell #(
	parameter int IDX = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              vld_i,
	input  logic signed [vrta_pkg::VecW-1:0]  x_i,
	input  logic signed [vrta_pkg::VecW-1:0]  y_i,
	input  logic [31:0]                       z_i,
	input  vrta_pkg::side_t                   side_i,
	output logic                              vld_o,
	output logic signed [vrta_pkg::VecW-1:0]  x_o,
	output logic signed [vrta_pkg::VecW-1:0]  y_o,
	output logic [31:0]                       z_o,
	output vrta_pkg::side_t                   side_o
);

	logic signed [vrta_pkg::VecW-1:0] dx;
	logic signed [vrta_pkg::VecW-1:0] dy;
	logic                             vld_q;
	logic signed [vrta_pkg::VecW-1:0] x_q;
	logic signed [vrta_pkg::VecW-1:0] y_q;
	logic [31:0]                      z_q;
	vrta_pkg::side_t                  side_q;

	assign dx = y_i >>> IDX;
	assign dy = x_i >>> IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_i;
			if (y_i[vrta_pkg::VecW-1]) begin
				x_q <= x_i - dx;
				y_q <= y_i + dy;
				z_q <= z_i - vrta_pkg::ATAN_TABLE[IDX];
			end else begin
				x_q <= x_i + dx;
				y_q <= y_i - dy;
				z_q <= z_i + vrta_pkg::ATAN_TABLE[IDX];
			end
		end
	end

	assign vld_o = vld_q;
	assign x_o = x_q;
	assign y_o = y_q;
	assign z_o = z_q;
	assign side_o = side_q;

endmodule

// ===== hdl/vrta_rot_cell.sv =====
// One rotation cell of the turning chain: a single CORDIC micro-rotation
// that drives the residual angle toward zero. Uses vrta_pkg.
module vrta_rot_cell #(
	parameter int IDX = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              vld_i,
	input  logic signed [vrta_pkg::VecW-1:0]  x_i,
	input  logic signed [vrta_pkg::VecW-1:0]  y_i,
	input  logic signed [vrta_pkg::ResW-1:0]  r_i,
	input  logic                              hit_i,
	output logic                              vld_o,
	output logic signed [vrta_pkg::VecW-1:0]  x_o,
	output logic signed [vrta_pkg::VecW-1:0]  y_o,
	output logic signed [vrta_pkg::ResW-1:0]  r_o,
	output logic                              hit_o
);

	logic signed [vrta_pkg::VecW-1:0] dx;
	logic signed [vrta_pkg::VecW-1:0] dy;
	logic signed [vrta_pkg::ResW-1:0] at;
	logic                             vld_q;
	logic signed [vrta_pkg::VecW-1:0] x_q;
	logic signed [vrta_pkg::VecW-1:0] y_q;
	logic signed [vrta_pkg::ResW-1:0] r_q;
	logic                             hit_q;

	assign dx = y_i >>> IDX;
	assign dy = x_i >>> IDX;
	assign at = $signed({{(vrta_pkg::ResW-32){1'b0}}, vrta_pkg::ATAN_TABLE[IDX]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= hit_i;
			if (!r_i[vrta_pkg::ResW-1]) begin
				x_q <= x_i - dx;
				y_q <= y_i + dy;
				r_q <= r_i - at;
			end else begin
				x_q <= x_i + dx;
				y_q <= y_i - dy;
				r_q <= r_i + at;
			end
		end
	end

	assign vld_o = vld_q;
	assign x_o = x_q;
	assign y_o = y_q;
	assign r_o = r_q;
	assign hit_o = hit_q;

endmodule

// ===== hdl/vrta_gain.sv =====
// Gain correction of one vector component: magnitude times the inverse
// CORDIC gain, rounded to Q16.16 half away from zero, saturated. Uses vrta_pkg.
module vrta_gain (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [vrta_pkg::VecW-1:0]  v_i,
	output logic [31:0]                       res_o
);

	localparam int W = vrta_pkg::VecW;
	localparam int L = vrta_pkg::LoSplit;
	localparam int SW = W + 32;

	logic             neg_s1;
	logic [W-1:0]     m_s1;
	logic             neg_s2;
	logic [W-L+31:0]  ph_s2;
	logic [L+31:0]    pl_s2;
	logic [SW-1:0]    sum;
	logic [W-17:0]    r;
	logic [31:0]      res_s3;

	always_comb begin
		sum = {ph_s2, {L{1'b0}}} + {{(SW-L-32){1'b0}}, pl_s2}
			+ ({{(SW-1){1'b0}}, 1'b1} << 47);
		r = sum[SW-1:48];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= v_i[W-1];
			m_s1 <= v_i[W-1] ? $unsigned(-v_i) : $unsigned(v_i);
			neg_s2 <= neg_s1;
			ph_s2 <= {{32{1'b0}}, m_s1[W-1:L]} * {{(W-L){1'b0}}, vrta_pkg::InvGain};
			pl_s2 <= {{32{1'b0}}, m_s1[L-1:0]} * {{L{1'b0}}, vrta_pkg::InvGain};
			if (neg_s2) begin
				if (r >= {{(W-48){1'b0}}, 32'h8000_0000}) begin
					res_s3 <= 32'h8000_0000;
				end else begin
					res_s3 <= 32'd0 - r[31:0];
				end
			end else begin
				if (r > {{(W-48){1'b0}}, 32'h7FFF_FFFF}) begin
					res_s3 <= 32'h7FFF_FFFF;
				end else begin
					res_s3 <= r[31:0];
				end
			end
		end
	end

	assign res_o = res_s3;

endmodule

// ===== hdl/vector_rotate_toward_angle_unit.sv =====
// Top level of the vector rotate-toward-angle unit.
// Instantiates the vectoring and rotation cell chains and two gain units.
// Uses vrta_pkg.
//
// The input channel takes one word per cycle while in_stall is low: a Q16.16 vector, a target heading
// and a largest turn step. A chain of CORDIC_STEPS vectoring cells finds the
// vector's heading, a decision stage wraps the angle difference and picks the
// turn, a pre-rotation stage handles turns beyond a quarter turn, a chain of
// CORDIC_STEPS rotation cells applies the turn, and two gain units correct,
// round and saturate x and y. Each cell is one register stage.
// A word passes the input register, the cell chains with the decision and
// pre-rotation registers, the gain registers and the output register.
// Throughput is one word per cycle while in_stall is low, set by the fully pipelined cell chains.
// Reset clears every valid bit, so no word is in flight afterwards.
// When the receiver stalls, the output register holds its word and one more
// word drains into a skid register; the pipeline then freezes and in_stall
// rises until the skid register empties. in_stall comes from a register only.
module vector_rotate_toward_angle_unit #(
	parameter int CORDIC_STEPS = vrta_pkg::DefSteps
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  start_x,
	input  logic signed [31:0]  start_y,
	input  logic signed [15:0]  target_angle,
	input  logic [14:0]         max_step,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  new_x,
	output logic signed [31:0]  new_y,
	output logic                reached
);

	localparam int W = vrta_pkg::VecW;
	localparam int RW = vrta_pkg::ResW;
	localparam int N = CORDIC_STEPS;

	logic en;

	logic signed [W-1:0] ex;
	logic signed [W-1:0] ey;
	vrta_pkg::side_t     side_in;

	logic                vv [0:N];
	logic signed [W-1:0] vx [0:N];
	logic signed [W-1:0] vy [0:N];
	logic [31:0]         vz [0:N];
	vrta_pkg::side_t     vs [0:N];

	logic [31:0]         heading;
	logic [31:0]         du;
	logic signed [32:0]  d;
	logic signed [32:0]  stp;
	logic                hit;
	logic signed [32:0]  rsel;

	logic                dv_s1;
	logic signed [32:0]  dr_s1;
	logic                dh_s1;
	logic [31:0]         dx0_s1;
	logic [31:0]         dy0_s1;

	logic signed [W-1:0]  px;
	logic signed [W-1:0]  py;
	logic signed [RW-1:0] pr;

	logic                 rv [0:N];
	logic signed [W-1:0]  rx [0:N];
	logic signed [W-1:0]  ry [0:N];
	logic signed [RW-1:0] rr [0:N];
	logic                 rh [0:N];

	logic        gv_s1, gv_s2, gv_s3;
	logic        gh_s1, gh_s2, gh_s3;
	logic [31:0] gx;
	logic [31:0] gy;

	logic        out_valid_q;
	logic [31:0] out_x_q;
	logic [31:0] out_y_q;
	logic        out_hit_q;
	logic        skid_valid_q;
	logic [31:0] skid_x_q;
	logic [31:0] skid_y_q;
	logic        skid_hit_q;
	logic        out_free;

	assign en = !skid_valid_q;
	assign in_stall = skid_valid_q;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		ex = $signed({{(W-48){start_x[31]}}, start_x, 16'd0});
		ey = $signed({{(W-48){start_y[31]}}, start_y, 16'd0});
		side_in.tgt = target_angle;
		side_in.stp = max_step;
		side_in.x0 = start_x;
		side_in.y0 = start_y;
		side_in.zero = (start_x == 32'sd0) && (start_y == 32'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vv[0] <= 1'b0;
		end else if (en) begin
			vv[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vs[0] <= side_in;
			if (start_x[31]) begin
				vx[0] <= -ex;
				vy[0] <= -ey;
				vz[0] <= vrta_pkg::HalfTurn;
			end else begin
				vx[0] <= ex;
				vy[0] <= ey;
				vz[0] <= 32'd0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_vec
		vrta_vec_cell #(.IDX(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(vv[i]), .x_i(vx[i]), .y_i(vy[i]), .z_i(vz[i]), .side_i(vs[i]),
			.vld_o(vv[i+1]), .x_o(vx[i+1]), .y_o(vy[i+1]), .z_o(vz[i+1]),
			.side_o(vs[i+1])
		);
	end

	always_comb begin
		heading = vs[N].zero ? 32'd0 : vz[N];
		du = {vs[N].tgt, 16'd0} - heading;
		d = (du > vrta_pkg::HalfTurn) ? $signed({1'b1, du}) : $signed({1'b0, du});
		stp = $signed({2'b00, vs[N].stp, 16'd0});
		hit = (d <= stp) && (d >= -stp);
		if (hit) begin
			rsel = d;
		end else if (d > 33'sd0) begin
			rsel = stp;
		end else begin
			rsel = -stp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s1 <= 1'b0;
		end else if (en) begin
			dv_s1 <= vv[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dr_s1 <= rsel;
			dh_s1 <= hit;
			dx0_s1 <= vs[N].x0;
			dy0_s1 <= vs[N].y0;
		end
	end

	always_comb begin
		px = $signed({{(W-48){dx0_s1[31]}}, dx0_s1, 16'd0});
		py = $signed({{(W-48){dy0_s1[31]}}, dy0_s1, 16'd0});
		pr = RW'(dr_s1);
		if (dr_s1 > 33'sh0_4000_0000) begin
			px = -px;
			py = -py;
			pr = RW'(dr_s1) - $signed({{(RW-32){1'b0}}, vrta_pkg::HalfTurn});
		end else if (dr_s1 < -33'sh0_4000_0000) begin
			px = -px;
			py = -py;
			pr = RW'(dr_s1) + $signed({{(RW-32){1'b0}}, vrta_pkg::HalfTurn});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv[0] <= 1'b0;
		end else if (en) begin
			rv[0] <= dv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx[0] <= px;
			ry[0] <= py;
			rr[0] <= pr;
			rh[0] <= dh_s1;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		vrta_rot_cell #(.IDX(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(rv[i]), .x_i(rx[i]), .y_i(ry[i]), .r_i(rr[i]), .hit_i(rh[i]),
			.vld_o(rv[i+1]), .x_o(rx[i+1]), .y_o(ry[i+1]), .r_o(rr[i+1]),
			.hit_o(rh[i+1])
		);
	end

	vrta_gain u_gain_x (.clk(clk), .en(en), .v_i(rx[N]), .res_o(gx));
	vrta_gain u_gain_y (.clk(clk), .en(en), .v_i(ry[N]), .res_o(gy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gv_s1 <= 1'b0;
			gv_s2 <= 1'b0;
			gv_s3 <= 1'b0;
		end else if (en) begin
			gv_s1 <= rv[N];
			gv_s2 <= gv_s1;
			gv_s3 <= gv_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gh_s1 <= rh[N];
			gh_s2 <= gh_s1;
			gh_s3 <= gh_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= gv_s3;
			end
		end else if (gv_s3 && en) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_x_q <= skid_x_q;
				out_y_q <= skid_y_q;
				out_hit_q <= skid_hit_q;
			end else begin
				out_x_q <= gx;
				out_y_q <= gy;
				out_hit_q <= gh_s3;
			end
		end else if (en) begin
			skid_x_q <= gx;
			skid_y_q <= gy;
			skid_hit_q <= gh_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign new_x = $signed(out_x_q);
	assign new_y = $signed(out_y_q);
	assign reached = out_hit_q;

`ifndef SYNTH
	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held without an output word");
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall && gv_s3))
		else $error("skid register filled without a stalled output");
	a_out_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q)
		else $error("stalled output word was dropped");
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !out_stall |=> !skid_valid_q && out_valid_q)
		else $error("skid word did not move to the output");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for vector_rotate_toward_angle_unit.
// Directed table then random words, checked against an in-bench CORDIC predictor.
// Depends on vrta_pkg and the unit under test.
module tb;

	localparam int Steps = vrta_pkg::DefSteps;
	localparam int NumRand = 1250;
	localparam int NumDir = 18;
	localparam int NumAll = NumDir + NumRand;
	localparam longint unsigned Half64 = 64'h8000_0000;
	localparam longint Quarter64 = 64'h4000_0000;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [15:0] tgt;
		logic [14:0]        stp;
		bit                 typed;
		logic [31:0]        ex;
		logic [31:0]        ey;
		logic               er;
	} row_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic        r;
		bit          typed;
		logic [31:0] tx;
		logic [31:0] ty;
		logic        tr;
	} turn_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] start_x = '0;
	logic signed [31:0] start_y = '0;
	logic signed [15:0] target_angle = '0;
	logic [14:0] max_step = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] new_x;
	logic signed [31:0] new_y;
	logic reached;

	row_t words [NumAll];
	turn_t pending_turns [$];
	int sent = 0;
	int offered = 0;
	int got = 0;
	int errors = 0;
	int snapped = 0;
	bit hold_done = 0;

	vector_rotate_toward_angle_unit dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] heading_of_vec(longint x, longint y);
		logic [31:0] z;
		longint dx, dy;
		z = '0;
		if (x == 0 && y == 0)
			return '0;
		x = x * 65536;
		y = y * 65536;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = vrta_pkg::HalfTurn;
		end
		for (int i = 0; i < Steps; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y < 0) begin
				x = x - dx;
				y = y + dy;
				z = z - vrta_pkg::ATAN_TABLE[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + vrta_pkg::ATAN_TABLE[i];
			end
		end
		return z;
	endfunction

	function automatic logic [31:0] gain_round_sat(longint v);
		bit neg;
		longint unsigned m, mh, ml, a, b, ah, al, r;
		neg = v < 0;
		m = neg ? longint'(-v) : longint'(v);
		mh = m >> 24;
		ml = m & 64'hFF_FFFF;
		a = mh * longint'(vrta_pkg::InvGain);
		b = ml * longint'(vrta_pkg::InvGain);
		ah = a >> 24;
		al = a & 64'hFF_FFFF;
		r = ah + (((al << 24) + b + (64'd1 << 47)) >> 48);
		if (neg) begin
			if (r >= 64'h8000_0000)
				return 32'h8000_0000;
			return 32'(-r);
		end
		if (r > 64'h7FFF_FFFF)
			r = 64'h7FFF_FFFF;
		return r[31:0];
	endfunction

	function automatic turn_t turn_toward(row_t w);
		turn_t t;
		longint x, y, d, stp, r, dx, dy;
		logic [31:0] du;
		x = longint'(w.x);
		y = longint'(w.y);
		du = {w.tgt, 16'h0000} - heading_of_vec(x, y);
		d = (du > vrta_pkg::HalfTurn) ? longint'(du) - 64'sh1_0000_0000 : longint'(du);
		stp = longint'({w.stp, 16'h0000});
		t.r = (d <= stp) && (d >= -stp);
		r = t.r ? d : (d > 0 ? stp : -stp);
		x = x * 65536;
		y = y * 65536;
		if (r > Quarter64) begin
			x = -x;
			y = -y;
			r = r - longint'(Half64);
		end else if (r < -Quarter64) begin
			x = -x;
			y = -y;
			r = r + longint'(Half64);
		end
		for (int i = 0; i < Steps; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (r >= 0) begin
				x = x - dx;
				y = y + dy;
				r = r - longint'(vrta_pkg::ATAN_TABLE[i]);
			end else begin
				x = x + dx;
				y = y - dy;
				r = r + longint'(vrta_pkg::ATAN_TABLE[i]);
			end
		end
		t.x = gain_round_sat(x);
		t.y = gain_round_sat(y);
		t.typed = w.typed;
		t.tx = w.ex;
		t.ty = w.ey;
		t.tr = w.er;
		return t;
	endfunction

	function automatic row_t make_row(logic [31:0] x, logic [31:0] y, logic [15:0] tgt,
			logic [14:0] stp);
		row_t w;
		w.x = x;
		w.y = y;
		w.tgt = tgt;
		w.stp = stp;
		w.typed = 0;
		w.ex = '0;
		w.ey = '0;
		w.er = 1'b0;
		return w;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 3) == 0 ? 32'h7FFF_FFFF : 32'h8000_0000;
			1: return 32'($signed($urandom_range(0, 2000)) - 1000);
			2: return 32'($signed($urandom_range(0, 20'hF_FFFF)) - 20'sh8_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [14:0] rand_step();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return 15'($urandom_range(0, 64));
			2: return 15'h7FFF;
			default: return 15'($urandom);
		endcase
	endfunction

	initial begin
		// Zero vector: outputs are zero, reached compares the target with heading zero.
		words[0] = make_row(0, 0, 16'd0, 15'd0);
		words[0].typed = 1;
		words[0].er = 1'b1;
		words[1] = make_row(0, 0, 16'd100, 15'd0);
		words[1].typed = 1;
		words[2] = make_row(0, 0, 16'h8000, 15'h7FFF);
		words[2].typed = 1;
		words[3] = make_row(0, 0, 16'd200, 15'd200);
		words[3].typed = 1;
		words[3].er = 1'b1;
		words[4] = make_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000, 15'h7FFF);
		words[5] = make_row(32'h8000_0000, 32'h8000_0000, 16'h7FFF, 15'h7FFF);
		words[6] = make_row(32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 15'd0);
		words[7] = make_row(32'h0001_0000, 0, 16'h8000, 15'd1000);
		words[8] = make_row(32'h0001_0000, 0, 16'h4000, 15'd0);
		words[9] = make_row(32'hFFFF_0000, 0, 16'h0000, 15'd500);
		words[10] = make_row(0, 32'h0010_0000, 16'hC000, 15'h7FFF);
		words[11] = make_row(0, 32'hFFF0_0000, 16'h6000, 15'h3000);
		words[12] = make_row(32'h0000_0001, 32'hFFFF_FFFF, 16'h2000, 15'h7FFF);
		words[13] = make_row(32'h7FFF_FFFF, 0, 16'h4000, 15'h4000);
		words[14] = make_row(32'h7FFF_FFFF, 0, 16'h5000, 15'h4FFF);
		words[15] = make_row(32'h0003_0000, 32'h0004_0000, 16'hA000, 15'h7FFE);
		words[16] = make_row(32'h8000_0000, 0, 16'h0000, 15'd0);
		words[17] = make_row(32'h1234_5678, 32'h8765_4321, 16'h1234, 15'h5555);
		for (int i = NumDir; i < NumAll; i++)
			words[i] = make_row(rand_coord(), rand_coord(), 16'($urandom), rand_step());
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		int burst, gap;
		burst = 0;
		gap = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (in_valid && !in_stall) begin
				pending_turns.push_back(turn_toward(words[sent]));
				sent++;
			end
			if (!(in_valid && in_stall)) begin
				if (burst == 0 && gap == 0) begin
					burst = $urandom_range(1, 40);
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
				if (burst > 0 && offered < NumAll) begin
					burst--;
					start_x <= words[offered].x;
					start_y <= words[offered].y;
					target_angle <= words[offered].tgt;
					max_step <= words[offered].stp;
					in_valid <= 1'b1;
					offered++;
				end else begin
					if (burst == 0 && gap > 0)
						gap--;
					in_valid <= 1'b0;
				end
			end
		end
	end

	initial begin
		int mode;
		mode = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && sent >= 400) begin
				hold_done = 1;
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				if ($urandom_range(0, 31) == 0)
					mode = $urandom_range(0, 3);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		turn_t t;
		if (out_valid && !out_stall) begin
			if (pending_turns.size() == 0) begin
				$display("%0t: unexpected word x=%h y=%h reached=%b", $time, new_x, new_y,
					reached);
				errors++;
			end else begin
				t = pending_turns.pop_front();
				if (t.typed && (t.tx !== t.x || t.ty !== t.y || t.tr !== t.r)) begin
					$display("%0t: predictor disagrees with table: %h %h %b vs %h %h %b",
						$time, t.tx, t.ty, t.tr, t.x, t.y, t.r);
					errors++;
				end
				if (new_x !== t.x) begin
					$display("%0t: new_x expected %h actual %h", $time, t.x, new_x);
					errors++;
				end
				if (new_y !== t.y) begin
					$display("%0t: new_y expected %h actual %h", $time, t.y, new_y);
					errors++;
				end
				if (reached !== t.r) begin
					$display("%0t: reached expected %b actual %b", $time, t.r, reached);
					errors++;
				end
				if (t.r)
					snapped++;
			end
			got++;
		end
	end

	initial begin
		@(posedge arst_n);
		wait (sent == NumAll && pending_turns.size() == 0);
		repeat (100) @(posedge clk);
		if (pending_turns.size() != 0)
			errors++;
		$display("Covered %0d words (%0d directed), %0d results, %0d snapped to target.",
			sent, NumDir, got, snapped);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d words sent and %0d results.", sent, got);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/vrta_pkg.sv
hdl/vrta_vec_cell.sv
hdl/vrta_rot_cell.sv
hdl/vrta_gain.sv
hdl/vector_rotate_toward_angle_unit.sv
bench/tb.sv
